### hw/rtl/bjeq_pkg.sv
package bjeq_pkg;

	// Register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_DEBOUNCE_TIME   = 3'd0,
		REG_UP_THRESHOLD    = 3'd1,
		REG_DOWN_THRESHOLD  = 3'd2,
		REG_LEFT_THRESHOLD  = 3'd3,
		REG_RIGHT_THRESHOLD = 3'd4,
		REG_HOLD_TIME       = 3'd5
	} reg_idx_t;

	localparam int unsigned NUM_BUTTONS = 3;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned SAMPLE_W    = 10;
	localparam int unsigned MS_W        = 16;
	localparam int unsigned CFG_ADDR_W  = 3;
	localparam int unsigned IN_TDATA_W  = 56;
	localparam int unsigned OUT_TDATA_W = 8;

	// Reset values of the registers
	localparam logic [MS_W-1:0]     DEBOUNCE_RST = 16'd50;
	localparam logic [SAMPLE_W-1:0] UP_RST       = 10'd400;
	localparam logic [SAMPLE_W-1:0] DOWN_RST     = 10'd600;
	localparam logic [SAMPLE_W-1:0] LEFT_RST     = 10'd400;
	localparam logic [SAMPLE_W-1:0] RIGHT_RST    = 10'd600;
	localparam logic [MS_W-1:0]     HOLD_RST     = 16'd3000;

	typedef struct packed {
		logic [MS_W-1:0]     debounce_time;
		logic [SAMPLE_W-1:0] up_threshold;
		logic [SAMPLE_W-1:0] down_threshold;
		logic [SAMPLE_W-1:0] left_threshold;
		logic [SAMPLE_W-1:0] right_threshold;
		logic [MS_W-1:0]     hold_time;
	} cfg_t;

	// One poll, last field in the lowest bits
	typedef struct packed {
		logic [SAMPLE_W-1:0] x_sample;
		logic [SAMPLE_W-1:0] y_sample;
		logic                history_level;
		logic                delete_level;
		logic                save_level;
		logic [TIME_W-1:0]   time_ms;
	} poll_t;

	// Events of one poll, last field in the lowest bit
	typedef struct packed {
		logic shutdown_event;
		logic down_event;
		logic up_event;
		logic history_event;
		logic delete_event;
		logic save_event;
	} evt_t;

endpackage

### hw/rtl/bjeq_cfg_regs.sv
module bjeq_cfg_regs
	import bjeq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [MS_W-1:0]       cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register file, writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= DEBOUNCE_RST;
			cfg_q.up_threshold    <= UP_RST;
			cfg_q.down_threshold  <= DOWN_RST;
			cfg_q.left_threshold  <= LEFT_RST;
			cfg_q.right_threshold <= RIGHT_RST;
			cfg_q.hold_time       <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DEBOUNCE_TIME:   cfg_q.debounce_time   <= cfg_wdata;
				REG_UP_THRESHOLD:    cfg_q.up_threshold    <= cfg_wdata[SAMPLE_W-1:0];
				REG_DOWN_THRESHOLD:  cfg_q.down_threshold  <= cfg_wdata[SAMPLE_W-1:0];
				REG_LEFT_THRESHOLD:  cfg_q.left_threshold  <= cfg_wdata[SAMPLE_W-1:0];
				REG_RIGHT_THRESHOLD: cfg_q.right_threshold <= cfg_wdata[SAMPLE_W-1:0];
				REG_HOLD_TIME:       cfg_q.hold_time       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/bjeq_eval.sv
module bjeq_eval
	import bjeq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  upd,   // poll in the input stage moves on this cycle
	input  poll_t poll,
	output evt_t  evt
);

	logic [NUM_BUTTONS-1:0] levels_q;
	logic [TIME_W-1:0]      chg_time_q [NUM_BUTTONS];
	logic                   up_fired_q, down_fired_q;
	logic [TIME_W-1:0]      up_time_q, down_time_q;
	logic [TIME_W-1:0]      hold_start_q;
	logic                   hold_active_q, shut_fired_q;

	logic [NUM_BUTTONS-1:0] lvl;
	logic [NUM_BUTTONS-1:0] btn_take;
	logic [NUM_BUTTONS-1:0] btn_press;
	logic [TIME_W-1:0]      btn_dt [NUM_BUTTONS];
	logic [TIME_W-1:0]      up_dt, down_dt, hold_dt;
	logic                   y_up, y_down, x_off;
	logic                   up_fire, down_fire, shut_fire;

	assign lvl = {poll.history_level, poll.delete_level, poll.save_level};

	// Per-button debounce: accept a level change once the lockout is over
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			btn_dt[i]    = poll.time_ms - chg_time_q[i];
			btn_take[i]  = (lvl[i] != levels_q[i]) &&
				(btn_dt[i] > {{(TIME_W-MS_W){1'b0}}, cfg.debounce_time});
			btn_press[i] = btn_take[i] && !lvl[i];
		end
	end

	// Y tilt, one event per excursion with lockout since last event
	assign up_dt     = poll.time_ms - up_time_q;
	assign down_dt   = poll.time_ms - down_time_q;
	assign y_up      = poll.y_sample < cfg.up_threshold;
	assign y_down    = poll.y_sample > cfg.down_threshold;
	assign up_fire   = y_up && !up_fired_q &&
		(up_dt > {{(TIME_W-MS_W){1'b0}}, cfg.debounce_time});
	assign down_fire = y_down && !down_fired_q &&
		(down_dt > {{(TIME_W-MS_W){1'b0}}, cfg.debounce_time});

	// X hold: first off-center poll only starts the timer
	assign hold_dt   = poll.time_ms - hold_start_q;
	assign x_off     = (poll.x_sample < cfg.left_threshold) ||
		(poll.x_sample > cfg.right_threshold);
	assign shut_fire = x_off && hold_active_q && !shut_fired_q &&
		(hold_dt >= {{(TIME_W-MS_W){1'b0}}, cfg.hold_time});

	assign evt = '{
		shutdown_event: shut_fire,
		down_event:     down_fire,
		up_event:       up_fire,
		history_event:  btn_press[2],
		delete_event:   btn_press[1],
		save_event:     btn_press[0]
	};

	// State update as the poll retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q      <= '1;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				chg_time_q[i] <= '0;
			end
			up_fired_q    <= 1'b0;
			down_fired_q  <= 1'b0;
			up_time_q     <= '0;
			down_time_q   <= '0;
			hold_start_q  <= '0;
			hold_active_q <= 1'b0;
			shut_fired_q  <= 1'b0;
		end else if (upd) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (btn_take[i]) begin
					levels_q[i]   <= lvl[i];
					chg_time_q[i] <= poll.time_ms;
				end
			end
			if (!y_up) begin
				up_fired_q <= 1'b0;
			end else if (up_fire) begin
				up_fired_q <= 1'b1;
				up_time_q  <= poll.time_ms;
			end
			if (!y_down) begin
				down_fired_q <= 1'b0;
			end else if (down_fire) begin
				down_fired_q <= 1'b1;
				down_time_q  <= poll.time_ms;
			end
			if (!x_off) begin
				hold_active_q <= 1'b0;
				shut_fired_q  <= 1'b0;
			end else if (!hold_active_q) begin
				hold_active_q <= 1'b1;
				hold_start_q  <= poll.time_ms;
				shut_fired_q  <= 1'b0;
			end else if (shut_fire) begin
				shut_fired_q <= 1'b1;
			end
		end
	end

	// A shutdown never fires twice without X returning to center first
	a_shut_once: assert property (@(posedge clk) disable iff (!arst_n)
		upd && shut_fire |=> shut_fired_q && hold_active_q)
		else $error("shutdown flag not latched after firing");

	// Shutdown only fires on a hold that was already running
	a_shut_hold: assert property (@(posedge clk) disable iff (!arst_n)
		shut_fire |-> hold_active_q)
		else $error("shutdown without an active hold");

	// An accepted save press leaves the stored level low
	a_press_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		upd && btn_press[0] |=> !levels_q[0])
		else $error("save press did not update the stored level");

	// An up event latches the fired flag and records its poll time
	a_up_zone: assert property (@(posedge clk) disable iff (!arst_n)
		upd && up_fire |=> up_fired_q && up_time_q == $past(poll.time_ms))
		else $error("up event state not recorded");

endmodule

### hw/rtl/button_joystick_event_qualifier_core.sv
// A poll accepted into the input register shows its events on m_tdata once it moves into the
// result register; a full result register with m_tready low holds it in the input register.
// Throughput: one poll per cycle while m_tready is high; the input register only takes
// a new poll while a result waits if the input register itself is empty.
// Reset (arst_n low, asynchronous): both stages empty, buttons released,
// timers and flags cleared, registers back to their default values.
module button_joystick_event_qualifier_core
	import bjeq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [MS_W-1:0]        cfg_wdata,
	// poll beats
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// time_ms[31:0], save_level, delete_level, history_level, y_sample, x_sample, pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// result beats
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// save, delete, history, up, down, shutdown event, pad
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	cfg_t  cfg;
	poll_t poll_s1;
	logic  vld_s1;
	evt_t  evt;
	evt_t  evt_s2;
	logic  vld_s2;
	logic  adv;

	bjeq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Result stage frees when empty or taken this cycle
	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			poll_s1 <= poll_t'(s_tdata[$bits(poll_t)-1:0]);
		end
	end

	bjeq_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.upd    (adv),
		.poll   (poll_s1),
		.evt    (evt)
	);

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || m_tready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			evt_s2 <= evt;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {{(OUT_TDATA_W-$bits(evt_t)){1'b0}}, evt_s2};

	// A poll moving out of the input stage always lands in the result stage
	a_adv_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> vld_s2)
		else $error("retired poll lost between stages");

	// An empty input stage never stalls the upstream side
	a_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	// A waiting result that is not taken holds the poll in the input stage
	a_s1_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 && !m_tready |=> vld_s1)
		else $error("stalled poll dropped from input stage");

endmodule

### tb/testbench.sv
module testbench;
	import bjeq_pkg::*;

	// indexes past the last register; writes to them must change nothing
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

	// sample zones used to steer joystick stimulus
	typedef enum int {
		ZONE_CENTER,
		ZONE_LOW,
		ZONE_HIGH,
		ZONE_ANY
	} zone_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_ADDR_W-1:0]  cfg_addr;
	logic [MS_W-1:0]        cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	// time_ms[31:0], save_level, delete_level, history_level, y_sample, x_sample, pad
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	// save, delete, history, up, down, shutdown event, pad
	logic [OUT_TDATA_W-1:0] m_tdata;

	// shadow of the block: registers and qualifier state
	cfg_t                   cfg_shadow;
	logic [NUM_BUTTONS-1:0] btn_level;
	logic [TIME_W-1:0]      btn_change_ms [NUM_BUTTONS];
	logic                   up_latched;
	logic                   down_latched;
	logic [TIME_W-1:0]      up_last_ms;
	logic [TIME_W-1:0]      down_last_ms;
	logic [TIME_W-1:0]      hold_since_ms;
	logic                   holding;
	logic                   shutdown_done;

	evt_t                   pending_events [$];
	evt_t                   want_ev;
	evt_t                   got_ev;
	int                     mismatch_count;
	bit                     calm;
	int                     gap_odds;

	// random stimulus state
	logic [TIME_W-1:0]      now_ms;
	logic [NUM_BUTTONS-1:0] drive_levels;
	zone_t                  y_zone;
	zone_t                  x_zone;

	button_joystick_event_qualifier_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// qualifier model
	// ------------------------------------------------------------------
	function automatic void reset_qualifier();
		int i;
		cfg_shadow.debounce_time   = DEBOUNCE_RST;
		cfg_shadow.up_threshold    = UP_RST;
		cfg_shadow.down_threshold  = DOWN_RST;
		cfg_shadow.left_threshold  = LEFT_RST;
		cfg_shadow.right_threshold = RIGHT_RST;
		cfg_shadow.hold_time       = HOLD_RST;
		btn_level = '1;
		for (i = 0; i < NUM_BUTTONS; i++)
			btn_change_ms[i] = '0;
		up_latched    = 1'b0;
		down_latched  = 1'b0;
		up_last_ms    = '0;
		down_last_ms  = '0;
		hold_since_ms = '0;
		holding       = 1'b0;
		shutdown_done = 1'b0;
	endfunction

	// strictly more than the debounce time since then_t, modulo 2^32
	function automatic logic lockout_over(input logic [TIME_W-1:0] now_t,
					      input logic [TIME_W-1:0] then_t);
		logic [TIME_W-1:0] gap;
		gap = now_t - then_t;
		return gap > TIME_W'(cfg_shadow.debounce_time);
	endfunction

	function automatic evt_t qualify_poll(input poll_t p);
		evt_t                   ev;
		logic [NUM_BUTTONS-1:0] lvl;
		logic [NUM_BUTTONS-1:0] press;
		logic [TIME_W-1:0]      held_for;
		int                     i;
		ev    = '0;
		press = '0;
		lvl   = {p.history_level, p.delete_level, p.save_level};

		// debounced level changes; a change to low is a press
		for (i = 0; i < NUM_BUTTONS; i++) begin
			if (lvl[i] != btn_level[i] && lockout_over(p.time_ms, btn_change_ms[i])) begin
				btn_change_ms[i] = p.time_ms;
				btn_level[i]     = lvl[i];
				press[i]         = ~lvl[i];
			end
		end
		ev.save_event    = press[0];
		ev.delete_event  = press[1];
		ev.history_event = press[2];

		// tilt down, once per excursion
		if (p.y_sample > cfg_shadow.down_threshold) begin
			if (!down_latched && lockout_over(p.time_ms, down_last_ms)) begin
				ev.down_event = 1'b1;
				down_latched  = 1'b1;
				down_last_ms  = p.time_ms;
			end
		end else begin
			down_latched = 1'b0;
		end

		// tilt up, once per excursion
		if (p.y_sample < cfg_shadow.up_threshold) begin
			if (!up_latched && lockout_over(p.time_ms, up_last_ms)) begin
				ev.up_event = 1'b1;
				up_latched  = 1'b1;
				up_last_ms  = p.time_ms;
			end
		end else begin
			up_latched = 1'b0;
		end

		// X hold: first off-center poll only starts the timer
		if (p.x_sample < cfg_shadow.left_threshold ||
		    p.x_sample > cfg_shadow.right_threshold) begin
			held_for = p.time_ms - hold_since_ms;
			if (!holding) begin
				holding       = 1'b1;
				hold_since_ms = p.time_ms;
				shutdown_done = 1'b0;
			end else if (!shutdown_done && held_for >= TIME_W'(cfg_shadow.hold_time)) begin
				ev.shutdown_event = 1'b1;
				shutdown_done     = 1'b1;
			end
		end else begin
			holding       = 1'b0;
			shutdown_done = 1'b0;
		end
		return ev;
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_ev = evt_t'(m_tdata[$bits(evt_t)-1:0]);
			if (pending_events.size() == 0) begin
				$error("result beat with no poll outstanding, m_tdata=%h", m_tdata);
				mismatch_count++;
			end else begin
				want_ev = pending_events.pop_front();
				check_field("save_event", want_ev.save_event, got_ev.save_event);
				check_field("delete_event", want_ev.delete_event, got_ev.delete_event);
				check_field("history_event", want_ev.history_event, got_ev.history_event);
				check_field("up_event", want_ev.up_event, got_ev.up_event);
				check_field("down_event", want_ev.down_event, got_ev.down_event);
				check_field("shutdown_event", want_ev.shutdown_event, got_ev.shutdown_event);
			end
		end
	end

	// result side backpressure
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			m_tready <= 1'b1;
			if ($urandom_range(0, 15) == 0)
				repeat ($urandom_range(20, 80)) @(negedge clk);
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	function automatic poll_t make_poll(input logic [TIME_W-1:0] t, input logic save_l,
					    input logic delete_l, input logic history_l,
					    input logic [SAMPLE_W-1:0] y, input logic [SAMPLE_W-1:0] x);
		poll_t p;
		p.time_ms       = t;
		p.save_level    = save_l;
		p.delete_level  = delete_l;
		p.history_level = history_l;
		p.y_sample      = y;
		p.x_sample      = x;
		return p;
	endfunction

	task automatic pause_sender(input int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// one poll beat; the expectation is recorded at the accepting edge
	task automatic send_poll(input poll_t p);
		if (!calm && $urandom_range(1, gap_odds) == 1)
			pause_sender($urandom_range(1, 14));
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'(p);
		do @(posedge clk); while (!s_tready);
		pending_events.push_back(qualify_poll(p));
	endtask

	// stop sending and wait until every poll has its result back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_register(input logic [CFG_ADDR_W-1:0] idx, input logic [MS_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DEBOUNCE_TIME:   cfg_shadow.debounce_time   = value;
			REG_UP_THRESHOLD:    cfg_shadow.up_threshold    = value[SAMPLE_W-1:0];
			REG_DOWN_THRESHOLD:  cfg_shadow.down_threshold  = value[SAMPLE_W-1:0];
			REG_LEFT_THRESHOLD:  cfg_shadow.left_threshold  = value[SAMPLE_W-1:0];
			REG_RIGHT_THRESHOLD: cfg_shadow.right_threshold = value[SAMPLE_W-1:0];
			REG_HOLD_TIME:       cfg_shadow.hold_time       = value;
			default: ;
		endcase
	endtask

	// full register set; threshold writes carry junk in the unused upper bits
	task automatic apply_config(input logic [MS_W-1:0] deb, input logic [SAMPLE_W-1:0] up,
				    input logic [SAMPLE_W-1:0] dn, input logic [SAMPLE_W-1:0] lf,
				    input logic [SAMPLE_W-1:0] rt, input logic [MS_W-1:0] hold);
		drain_results();
		set_register(REG_DEBOUNCE_TIME, deb);
		set_register(REG_UP_THRESHOLD, {6'($urandom), up});
		set_register(REG_DOWN_THRESHOLD, {6'($urandom), dn});
		set_register(REG_LEFT_THRESHOLD, {6'($urandom), lf});
		set_register(REG_RIGHT_THRESHOLD, {6'($urandom), rt});
		set_register(REG_HOLD_TIME, hold);
		if ($urandom_range(0, 1))
			set_register($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample(input zone_t zone,
							     input logic [SAMPLE_W-1:0] lo_thr,
							     input logic [SAMPLE_W-1:0] hi_thr);
		logic [SAMPLE_W-1:0] s;
		case (zone)
			ZONE_CENTER: s = SAMPLE_W'($urandom_range(lo_thr, hi_thr));
			ZONE_LOW:    s = SAMPLE_W'($urandom_range(0, lo_thr));
			ZONE_HIGH:   s = SAMPLE_W'($urandom_range(hi_thr, 1023));
			default:     s = SAMPLE_W'($urandom);
		endcase
		return s;
	endfunction

	// next poll: time steps clustered around the lockout and hold times,
	// buttons toggling, joystick zones that persist for a few polls
	task automatic random_poll();
		int          r;
		int          cap;
		int unsigned step;
		int          i;
		r   = $urandom_range(0, 99);
		cap = 2 * int'(cfg_shadow.debounce_time) + 3;
		if (int'(cfg_shadow.hold_time) / 2 > cap)
			cap = int'(cfg_shadow.hold_time) / 2;
		if (r < 8)
			step = 0;
		else if (r < 16)
			step = 32'(cfg_shadow.debounce_time);
		else if (r < 24)
			step = 32'(cfg_shadow.debounce_time) + 32'd1;
		else if (r < 30)
			step = 32'(cfg_shadow.hold_time);
		else
			step = $urandom_range(0, cap);
		if (r >= 96)
			now_ms = $urandom;
		else
			now_ms = now_ms + step;

		if ($urandom_range(0, 9) == 0) begin
			drive_levels = NUM_BUTTONS'($urandom);
		end else begin
			for (i = 0; i < NUM_BUTTONS; i++)
				if ($urandom_range(0, 4) == 0)
					drive_levels[i] = ~drive_levels[i];
		end
		if ($urandom_range(0, 5) == 0)
			y_zone = zone_t'($urandom_range(0, 3));
		if ($urandom_range(0, 5) == 0)
			x_zone = zone_t'($urandom_range(0, 3));

		send_poll(make_poll(now_ms, drive_levels[0], drive_levels[1], drive_levels[2],
				    pick_sample(y_zone, cfg_shadow.up_threshold,
						cfg_shadow.down_threshold),
				    pick_sample(x_zone, cfg_shadow.left_threshold,
						cfg_shadow.right_threshold)));
	endtask

	task automatic random_phase(input int count, input int pause_at);
		int k;
		if ($urandom_range(0, 2) == 0)
			now_ms = '1 - TIME_W'($urandom_range(0, 2000));
		gap_odds = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(2, 8);
		for (k = 0; k < count; k++) begin
			if (k == pause_at)
				drain_results();
			random_poll();
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_button_debounce();
		send_poll(make_poll(32'd0, 1'b1, 1'b1, 1'b1, 10'd500, 10'd500));
		// exactly the debounce time is still locked out
		send_poll(make_poll(32'd50, 1'b0, 1'b1, 1'b1, 10'd500, 10'd500));
		send_poll(make_poll(32'd51, 1'b0, 1'b1, 1'b1, 10'd500, 10'd500));
		send_poll(make_poll(32'd101, 1'b1, 1'b1, 1'b1, 10'd500, 10'd500));
		// release accepted, no event
		send_poll(make_poll(32'd102, 1'b1, 1'b1, 1'b1, 10'd500, 10'd500));
		send_poll(make_poll(32'd200, 1'b0, 1'b0, 1'b0, 10'd500, 10'd500));
	endtask

	task automatic test_tilt_events();
		send_poll(make_poll(32'd1000, 1'b0, 1'b0, 1'b0, 10'd0, 10'd500));
		send_poll(make_poll(32'd1010, 1'b0, 1'b0, 1'b0, 10'd0, 10'd500));
		// back inside the band, then lockout against the last up event
		send_poll(make_poll(32'd1020, 1'b0, 1'b0, 1'b0, 10'd400, 10'd500));
		send_poll(make_poll(32'd1030, 1'b0, 1'b0, 1'b0, 10'd399, 10'd500));
		send_poll(make_poll(32'd1051, 1'b0, 1'b0, 1'b0, 10'd399, 10'd500));
		send_poll(make_poll(32'd1100, 1'b0, 1'b0, 1'b0, 10'd1023, 10'd500));
		send_poll(make_poll(32'd1150, 1'b0, 1'b0, 1'b0, 10'd600, 10'd500));
		send_poll(make_poll(32'd1151, 1'b0, 1'b0, 1'b0, 10'd601, 10'd500));
	endtask

	task automatic test_shutdown_hold();
		send_poll(make_poll(32'd2000, 1'b0, 1'b0, 1'b0, 10'd500, 10'd0));
		send_poll(make_poll(32'd4999, 1'b0, 1'b0, 1'b0, 10'd500, 10'd1023));
		send_poll(make_poll(32'd5000, 1'b0, 1'b0, 1'b0, 10'd500, 10'd1023));
		send_poll(make_poll(32'd5100, 1'b0, 1'b0, 1'b0, 10'd500, 10'd399));
		send_poll(make_poll(32'd5200, 1'b0, 1'b0, 1'b0, 10'd500, 10'd400));
		// zero hold time: the starting poll still cannot fire
		drain_results();
		set_register(REG_HOLD_TIME, 16'd0);
		send_poll(make_poll(32'd5300, 1'b0, 1'b0, 1'b0, 10'd500, 10'd601));
		send_poll(make_poll(32'd5300, 1'b0, 1'b0, 1'b0, 10'd500, 10'd601));
	endtask

	task automatic test_register_extremes();
		drain_results();
		set_register(REG_DEBOUNCE_TIME, 16'd0);
		set_register(REG_UP_THRESHOLD, 16'hFFFF);
		set_register(REG_DOWN_THRESHOLD, 16'h0400);
		set_register(REG_LEFT_THRESHOLD, 16'hFC00);
		set_register(REG_RIGHT_THRESHOLD, 16'h03FF);
		set_register(REG_HOLD_TIME, 16'hFFFF);
		set_register(REG_SPARE_6, 16'h0001);
		set_register(REG_SPARE_7, 16'hFFFF);
		// both tilt directions at once, X can never leave center
		send_poll(make_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 10'd512, 10'd0));
		// presses across the timestamp wrap
		send_poll(make_poll(32'h0000_0000, 1'b0, 1'b0, 1'b0, 10'd1022, 10'd1023));
		// same timestamp: zero lockout still blocks
		send_poll(make_poll(32'h0000_0000, 1'b1, 1'b1, 1'b1, 10'd1, 10'd512));
		send_poll(make_poll(32'h0000_0001, 1'b1, 1'b1, 1'b1, 10'd1023, 10'd0));
	endtask

	task automatic test_random_traffic();
		now_ms       = 32'd6000;
		drive_levels = '1;
		y_zone       = ZONE_CENTER;
		x_zone       = ZONE_CENTER;

		apply_config(DEBOUNCE_RST, UP_RST, DOWN_RST, LEFT_RST, RIGHT_RST, 16'd200);
		random_phase(150, -1);

		apply_config(16'($urandom_range(0, 200)), 10'($urandom_range(0, 1023)),
			     10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
			     10'($urandom_range(0, 1023)), 16'($urandom_range(0, 400)));
		random_phase(150, -1);

		// zero lockout and hold, plus one full stop mid-phase
		apply_config(16'd0, 10'd512, 10'd511, 10'd300, 10'd700, 16'd0);
		random_phase(150, 75);

		apply_config(16'hFFFF, 10'd1023, 10'd0, 10'd1023, 10'd0, 16'hFFFF);
		random_phase(150, -1);

		apply_config(16'($urandom), 10'($urandom_range(200, 500)),
			     10'($urandom_range(500, 800)), 10'($urandom_range(200, 500)),
			     10'($urandom_range(500, 800)), 16'($urandom));
		random_phase(150, -1);

		// last stretch without any idling on either side
		apply_config(16'($urandom_range(0, 100)), 10'($urandom_range(300, 450)),
			     10'($urandom_range(550, 700)), 10'($urandom_range(300, 450)),
			     10'($urandom_range(550, 700)), 16'($urandom_range(0, 300)));
		calm = 1'b1;
		random_phase(150, -1);
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_addr       = '0;
		cfg_wdata      = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		calm           = 1'b0;
		gap_odds       = 6;
		mismatch_count = 0;
		reset_qualifier();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_button_debounce();
		test_tilt_events();
		test_shutdown_hold();
		test_register_extremes();
		test_random_traffic();

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("[button_joystick_event_qualifier_core] OK");
		else
			$display("[button_joystick_event_qualifier_core] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("[button_joystick_event_qualifier_core] ERROR");
		$finish;
	end

endmodule

### button_joystick_event_qualifier_core.f
hw/rtl/bjeq_pkg.sv
hw/rtl/bjeq_cfg_regs.sv
hw/rtl/bjeq_eval.sv
hw/rtl/button_joystick_event_qualifier_core.sv
tb/testbench.sv
